[rtl/core/zor_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zor_pkg
// Shared types, widths and command codes for the z-score outlier replacer.
// ----------------------------------------------------------------------------
package zor_pkg;

    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int VALUE_BITS = 27;
    localparam int CHANNELS   = 5;
    localparam int CH_W       = 3;
    localparam int STORE_W    = CHANNELS * VALUE_BITS;
    localparam int SUM_W      = 37;
    localparam int SQ_W       = 64;
    localparam int NX_W       = CNT_W + VALUE_BITS;
    localparam int VAR_W      = 76;
    localparam int THR_W      = 12;
    localparam int T2_W       = 2 * THR_W;
    localparam int DIG_W      = 8;
    localparam int MB_W       = 40;
    localparam int MUL_STEPS  = MB_W / DIG_W;
    localparam int MA_W       = VAR_W + MB_W - DIG_W;
    localparam int PROD_W     = MA_W + DIG_W;
    localparam int LHS_SHIFT  = 16;
    localparam int DND_W      = SUM_W + 2;
    localparam int REM_W      = CNT_W + 1;
    localparam int DIV_STEPS  = DND_W;
    localparam int TOTAL_W    = 13;
    localparam int STEP_W     = 6;

    localparam logic [THR_W-1:0] THR_RESET = 12'd768;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_SET = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_SQ        = 5'd2;
    localparam logic [OP_W-1:0] OP_ACC       = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL_NQ    = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL_SS    = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_DD    = 5'd6;
    localparam logic [OP_W-1:0] OP_MUL_VT    = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_STEP  = 5'd8;
    localparam logic [OP_W-1:0] OP_VAR_SAVE1 = 5'd9;
    localparam logic [OP_W-1:0] OP_VAR_SAVE2 = 5'd10;
    localparam logic [OP_W-1:0] OP_DIV_START = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd12;
    localparam logic [OP_W-1:0] OP_MEAN_SAVE = 5'd13;
    localparam logic [OP_W-1:0] OP_RD        = 5'd14;
    localparam logic [OP_W-1:0] OP_NX        = 5'd15;
    localparam logic [OP_W-1:0] OP_DIFF      = 5'd16;
    localparam logic [OP_W-1:0] OP_LHS_SAVE  = 5'd17;
    localparam logic [OP_W-1:0] OP_FLAG      = 5'd18;
    localparam logic [OP_W-1:0] OP_EMIT      = 5'd19;
    localparam logic [OP_W-1:0] OP_NOSET     = 5'd20;

    typedef struct packed {
        logic                  command;
        logic [VALUE_BITS-1:0] open_in;
        logic [VALUE_BITS-1:0] high_in;
        logic [VALUE_BITS-1:0] low_in;
        logic [VALUE_BITS-1:0] close_in;
        logic [VALUE_BITS-1:0] volume_in;
        logic                  last_in;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] open_out;
        logic [VALUE_BITS-1:0] high_out;
        logic [VALUE_BITS-1:0] low_out;
        logic [VALUE_BITS-1:0] close_out;
        logic [VALUE_BITS-1:0] volume_out;
        logic [CHANNELS-1:0]   outlier_mask;
        logic [TOTAL_W-1:0]    outlier_total;
        logic                  last_out;
        logic [1:0]            status;
    } t_out_item;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] chan;
    } t_dp_cmd;

    typedef struct packed {
        logic room;
        logic set_ready;
        logic out_full;
    } t_dp_status;

endpackage

[rtl/core/zor_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zor_datapath
// Record store, channel statistics, shared digit-serial multiplier, restoring
// divider for the means and the result register.
// ----------------------------------------------------------------------------
module zor_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  zor_pkg::t_in_item            i_in_item,
    input  zor_pkg::t_dp_cmd             i_cmd,
    output zor_pkg::t_dp_status          o_status,
    input  logic                         i_cfg_wr_en,
    input  logic [zor_pkg::THR_W-1:0]    i_cfg_wr_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output zor_pkg::t_out_item           o_out_item
);
    import zor_pkg::*;

    logic [STORE_W-1:0]    r_mem [DEPTH];
    logic [STORE_W-1:0]    r_rd;
    logic [VALUE_BITS-1:0] r_x [CHANNELS];
    logic [SUM_W-1:0]      r_sum [CHANNELS];
    logic [SQ_W-1:0]       r_sq [CHANNELS];
    logic [VAR_W-1:0]      r_var [CHANNELS];
    logic [VALUE_BITS-1:0] r_mean [CHANNELS];
    logic [VALUE_BITS-1:0] r_val [CHANNELS];
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_rp;
    logic                  r_set_ready;
    logic                  r_ovf;
    logic [TOTAL_W-1:0]    r_rc;
    logic [THR_W-1:0]      r_thr;
    logic [T2_W-1:0]       r_t2;
    logic [2*VALUE_BITS-1:0] r_sqp;
    logic [MA_W-1:0]       r_ma;
    logic [MB_W-1:0]       r_mb;
    logic [PROD_W-1:0]     r_acc;
    logic [PROD_W-1:0]     r_tmp;
    logic [NX_W-1:0]       r_nx;
    logic [NX_W-1:0]       r_d;
    logic [DND_W-1:0]      r_dnd;
    logic [DND_W-1:0]      r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [CHANNELS-1:0]   r_mask;
    logic                  r_ovalid;
    t_out_item             r_out;

    logic [CH_W-1:0]       w_c;
    logic [VALUE_BITS-1:0] w_x_load;
    logic [VALUE_BITS-1:0] w_x_rd;
    logic [CNT_W-1:0]      w_base_count;
    logic                  w_room;
    logic [PROD_W-1:0]     w_pp;
    logic [REM_W:0]        w_trial;
    logic [REM_W-1:0]      w_dvs;
    logic                  w_ge;
    logic [NX_W-1:0]       w_sum_ext;
    logic                  w_flag;
    logic [CNT_W-1:0]      w_next_rp;
    logic                  w_last;
    t_out_item             w_emit;
    t_out_item             w_noset;

    always_comb begin
        w_c          = i_cmd.chan;
        w_x_load     = r_x[w_c];
        w_x_rd       = r_rd[VALUE_BITS*w_c +: VALUE_BITS];
        w_base_count = r_set_ready ? '0 : r_count;
        w_room       = r_set_ready || (r_count < CNT_W'(DEPTH));
        w_pp         = r_ma * r_mb[DIG_W-1:0];
        w_trial      = {r_rem, r_dnd[DND_W-1]};
        w_dvs        = {r_count, 1'b0};
        w_ge         = w_trial >= {1'b0, w_dvs};
        w_sum_ext    = NX_W'(r_sum[w_c]);
        w_flag       = (|r_var[w_c]) && (r_tmp > r_acc);
        w_next_rp    = CNT_W'(r_rp) + CNT_W'(1);
        w_last       = w_next_rp >= r_count;
        w_emit.open_out      = r_val[0];
        w_emit.high_out      = r_val[1];
        w_emit.low_out       = r_val[2];
        w_emit.close_out     = r_val[3];
        w_emit.volume_out    = r_val[4];
        w_emit.outlier_mask  = r_mask;
        w_emit.outlier_total = r_rc;
        w_emit.last_out      = w_last;
        w_emit.status        = r_ovf ? ST_TRUNC : ST_OK;
        w_noset        = '0;
        w_noset.status = ST_NO_SET;
    end

    // record store: one write port on load, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && w_room) begin
            r_mem[w_base_count[ADDR_W-1:0]] <= {i_in_item.volume_in, i_in_item.close_in,
                                                i_in_item.low_in, i_in_item.high_in,
                                                i_in_item.open_in};
        end
        if (i_cmd.op == OP_RD) begin
            r_rd <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rp        <= '0;
            r_set_ready <= 1'b0;
            r_ovf       <= 1'b0;
            r_rc        <= '0;
            r_thr       <= THR_RESET;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_sq[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    // a load after a closed set starts a fresh one
                    if (r_set_ready) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_sum[i] <= '0;
                            r_sq[i]  <= '0;
                        end
                        r_ovf <= 1'b0;
                    end
                    if (w_room) begin
                        r_count <= w_base_count + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (r_set_ready || i_in_item.last_in) begin
                        r_rp <= '0;
                        r_rc <= '0;
                    end
                    r_set_ready <= i_in_item.last_in;
                end
                OP_ACC: begin
                    r_sum[w_c] <= r_sum[w_c] + SUM_W'(w_x_load);
                    r_sq[w_c]  <= r_sq[w_c] + SQ_W'(r_sqp);
                end
                OP_FLAG: begin
                    if (w_flag) begin
                        r_rc <= r_rc + TOTAL_W'(1);
                    end
                end
                OP_EMIT: begin
                    r_ovalid <= 1'b1;
                    if (w_last) begin
                        r_rp <= '0;
                        r_rc <= '0;
                    end else begin
                        r_rp <= w_next_rp[ADDR_W-1:0];
                    end
                end
                OP_NOSET: begin
                    r_ovalid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_t2 <= r_thr * r_thr;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x[0] <= i_in_item.open_in;
                r_x[1] <= i_in_item.high_in;
                r_x[2] <= i_in_item.low_in;
                r_x[3] <= i_in_item.close_in;
                r_x[4] <= i_in_item.volume_in;
            end
            OP_SQ: begin
                r_sqp <= w_x_load * w_x_load;
            end
            OP_MUL_NQ: begin
                r_ma  <= MA_W'(r_sq[w_c]);
                r_mb  <= MB_W'(r_count);
                r_acc <= '0;
            end
            OP_MUL_SS: begin
                r_ma  <= MA_W'(r_sum[w_c]);
                r_mb  <= MB_W'(r_sum[w_c]);
                r_acc <= '0;
            end
            OP_MUL_DD: begin
                r_ma  <= MA_W'(r_d);
                r_mb  <= MB_W'(r_d);
                r_acc <= '0;
            end
            OP_MUL_VT: begin
                r_ma  <= MA_W'(r_var[w_c]);
                r_mb  <= MB_W'(r_t2);
                r_acc <= '0;
            end
            OP_MUL_STEP: begin
                // one multiplier digit per cycle
                r_acc <= r_acc + w_pp;
                r_ma  <= r_ma << DIG_W;
                r_mb  <= r_mb >> DIG_W;
            end
            OP_VAR_SAVE1: begin
                r_tmp <= r_acc;
            end
            OP_VAR_SAVE2: begin
                r_var[w_c] <= VAR_W'(r_tmp - r_acc);
            end
            OP_DIV_START: begin
                r_dnd <= DND_W'({r_sum[w_c], 1'b0}) + DND_W'(r_count);
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_dnd <= r_dnd << 1;
                r_quo <= {r_quo[DND_W-2:0], w_ge};
                r_rem <= w_ge ? REM_W'(w_trial - {1'b0, w_dvs}) : REM_W'(w_trial);
            end
            OP_MEAN_SAVE: begin
                r_mean[w_c] <= r_quo[VALUE_BITS-1:0];
            end
            OP_RD: begin
                r_mask <= '0;
            end
            OP_NX: begin
                r_nx <= r_count * w_x_rd;
            end
            OP_DIFF: begin
                r_d <= (r_nx >= w_sum_ext) ? (r_nx - w_sum_ext) : (w_sum_ext - r_nx);
            end
            OP_LHS_SAVE: begin
                r_tmp <= {r_acc[PROD_W-LHS_SHIFT-1:0], {LHS_SHIFT{1'b0}}};
            end
            OP_FLAG: begin
                r_mask[w_c] <= w_flag;
                r_val[w_c]  <= w_flag ? r_mean[w_c] : w_x_rd;
            end
            OP_EMIT: begin
                r_out <= w_emit;
            end
            OP_NOSET: begin
                r_out <= w_noset;
            end
            default: begin
            end
        endcase
    end

    assign o_status.room      = w_room;
    assign o_status.set_ready = r_set_ready;
    assign o_status.out_full  = r_ovalid;
    assign o_out_valid        = r_ovalid;
    assign o_out_item         = r_out;

    a_ready_has_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_set_ready |-> (r_count != '0))
        else $error("closed set with no records");

    a_overflow_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(DEPTH)))
        else $error("overflow flagged below capacity");

    a_pointer_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_set_ready |-> (CNT_W'(r_rp) < r_count))
        else $error("read pointer beyond stored records");

endmodule

[rtl/core/zor_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zor_control
// Sequencer: accepts items, walks the channels and steps the shared
// multiplier and divider of the datapath.
// ----------------------------------------------------------------------------
module zor_control (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic                  i_last,
    input  zor_pkg::t_dp_status   i_status,
    output zor_pkg::t_dp_cmd      o_cmd
);
    import zor_pkg::*;

    localparam int S_W = 5;
    localparam logic [S_W-1:0] S_IDLE   = 5'd0;
    localparam logic [S_W-1:0] S_LSQ    = 5'd1;
    localparam logic [S_W-1:0] S_LACC   = 5'd2;
    localparam logic [S_W-1:0] S_NQ     = 5'd3;
    localparam logic [S_W-1:0] S_NQ_RUN = 5'd4;
    localparam logic [S_W-1:0] S_V1     = 5'd5;
    localparam logic [S_W-1:0] S_SS     = 5'd6;
    localparam logic [S_W-1:0] S_SS_RUN = 5'd7;
    localparam logic [S_W-1:0] S_V2     = 5'd8;
    localparam logic [S_W-1:0] S_DSTART = 5'd9;
    localparam logic [S_W-1:0] S_DRUN   = 5'd10;
    localparam logic [S_W-1:0] S_MEAN   = 5'd11;
    localparam logic [S_W-1:0] S_NX     = 5'd12;
    localparam logic [S_W-1:0] S_DIFF   = 5'd13;
    localparam logic [S_W-1:0] S_DD     = 5'd14;
    localparam logic [S_W-1:0] S_DD_RUN = 5'd15;
    localparam logic [S_W-1:0] S_LHS    = 5'd16;
    localparam logic [S_W-1:0] S_VT     = 5'd17;
    localparam logic [S_W-1:0] S_VT_RUN = 5'd18;
    localparam logic [S_W-1:0] S_FLAG   = 5'd19;
    localparam logic [S_W-1:0] S_EMIT   = 5'd20;

    localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    logic [S_W-1:0]    r_state;
    logic [S_W-1:0]    n_state;
    logic [CH_W-1:0]   r_chan;
    logic [CH_W-1:0]   n_chan;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_last;
    logic              n_last;
    logic [OP_W-1:0]   w_op;
    logic              w_accept;

    // a read waits while the previous result is still held
    assign o_in_stall = (r_state != S_IDLE) || ((i_command == CMD_READ) && i_status.out_full);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_step  = r_step;
        n_last  = r_last;
        w_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_chan = '0;
                    if (i_command == CMD_LOAD) begin
                        w_op   = OP_LOAD;
                        n_last = i_last;
                        if (i_status.room) begin
                            n_state = S_LSQ;
                        end else if (i_last) begin
                            n_state = S_NQ;
                        end
                    end else if (i_status.set_ready) begin
                        w_op    = OP_RD;
                        n_state = S_NX;
                    end else begin
                        w_op = OP_NOSET;
                    end
                end
            end
            S_LSQ: begin
                w_op    = OP_SQ;
                n_state = S_LACC;
            end
            S_LACC: begin
                w_op = OP_ACC;
                if (r_chan == LAST_CH) begin
                    n_chan  = '0;
                    n_state = r_last ? S_NQ : S_IDLE;
                end else begin
                    n_chan  = r_chan + CH_W'(1);
                    n_state = S_LSQ;
                end
            end
            S_NQ: begin
                w_op    = OP_MUL_NQ;
                n_step  = '0;
                n_state = S_NQ_RUN;
            end
            S_NQ_RUN: begin
                w_op = OP_MUL_STEP;
                if (r_step == MUL_LAST) begin
                    n_state = S_V1;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_V1: begin
                w_op    = OP_VAR_SAVE1;
                n_state = S_SS;
            end
            S_SS: begin
                w_op    = OP_MUL_SS;
                n_step  = '0;
                n_state = S_SS_RUN;
            end
            S_SS_RUN: begin
                w_op = OP_MUL_STEP;
                if (r_step == MUL_LAST) begin
                    n_state = S_V2;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_V2: begin
                w_op    = OP_VAR_SAVE2;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                w_op    = OP_DIV_START;
                n_step  = '0;
                n_state = S_DRUN;
            end
            S_DRUN: begin
                w_op = OP_DIV_STEP;
                if (r_step == DIV_LAST) begin
                    n_state = S_MEAN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_MEAN: begin
                w_op = OP_MEAN_SAVE;
                if (r_chan == LAST_CH) begin
                    n_chan  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_chan  = r_chan + CH_W'(1);
                    n_state = S_NQ;
                end
            end
            S_NX: begin
                w_op    = OP_NX;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                w_op    = OP_DIFF;
                n_state = S_DD;
            end
            S_DD: begin
                w_op    = OP_MUL_DD;
                n_step  = '0;
                n_state = S_DD_RUN;
            end
            S_DD_RUN: begin
                w_op = OP_MUL_STEP;
                if (r_step == MUL_LAST) begin
                    n_state = S_LHS;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_LHS: begin
                w_op    = OP_LHS_SAVE;
                n_state = S_VT;
            end
            S_VT: begin
                w_op    = OP_MUL_VT;
                n_step  = '0;
                n_state = S_VT_RUN;
            end
            S_VT_RUN: begin
                w_op = OP_MUL_STEP;
                if (r_step == MUL_LAST) begin
                    n_state = S_FLAG;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FLAG: begin
                w_op = OP_FLAG;
                if (r_chan == LAST_CH) begin
                    n_chan  = '0;
                    n_state = S_EMIT;
                end else begin
                    n_chan  = r_chan + CH_W'(1);
                    n_state = S_NX;
                end
            end
            S_EMIT: begin
                w_op    = OP_EMIT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= '0;
            r_step  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_step  <= n_step;
            r_last  <= n_last;
        end
    end

    assign o_cmd.op   = w_op;
    assign o_cmd.chan = r_chan;

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_status.out_full)
        else $error("result issued over a waiting item");

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_READ) && i_status.set_ready) |=> (r_state == S_NX))
        else $error("read did not start channel sweep");

    a_flag_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLAG) && (r_chan == LAST_CH)) |=> (r_state == S_EMIT))
        else $error("last channel did not lead to emit");

endmodule

[rtl/core/zscore_outlier_replacer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_outlier_replacer
// Stores five-channel records, then reads them back with z-score outliers
// replaced by the rounded channel mean.
// ----------------------------------------------------------------------------
// Load: one squarer pass per channel for each stored item, none for a dropped
//   record; a closing load also computes the statistics (39-step divider).
// Read: each channel in turn passes through the shared 8-bit-digit multiplier
//   before the result is registered; a read before a closed set yields ST_NO_SET.
// Reset (synchronous, active low) empties the set and sets the threshold to 3.0.
// ----------------------------------------------------------------------------
module zscore_outlier_replacer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  zor_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output zor_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [zor_pkg::THR_W-1:0]  i_cfg_wr_data
);
    import zor_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    zor_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_in_item.command),
        .i_last     (i_in_item.last_in),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    zor_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_item     (i_in_item),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule
